// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the timer queue rtl
// depends on nothing; checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, quiet while reset is held
`define STQ_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("timer queue check failed");
// clocked check that also runs through reset
`define STQ_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("timer queue reset check failed");
`else
`define STQ_ASSERT(label, clk, rstn, prop)
`define STQ_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== hw/rtl/stq_pkg.sv =====
// shared types and constants for the sorted timer queue
// depends on nothing; used by stq_dp, stq_ctrl and sorted_timer_queue_unit
`default_nettype none

package stq_pkg;

  // sizing
  localparam int CAPACITY    = 16;
  localparam int TIME_WIDTH  = 32;
  localparam int NUM_IDS     = 16;
  localparam int ID_W        = 4;
  localparam int PORT_TIME_W = 32;
  localparam int QUEUE_LIMIT = (CAPACITY < NUM_IDS) ? CAPACITY : NUM_IDS;
  localparam int CNT_W       = $clog2(QUEUE_LIMIT + 1);

  typedef logic [TIME_WIDTH-1:0] stq_time_t;
  typedef logic [ID_W-1:0]       stq_id_t;

  // request codes
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_ADJUST = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_TICK   = 2'd3
  } stq_req_t;

  // status codes
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_EXISTS     = 2'd1,
    STAT_NOT_ACTIVE = 2'd2
  } stq_status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_INSERT,
    S_TICK
  } stq_state_t;

  // controller to datapath
  typedef struct packed {
    logic        load;
    logic        insert;
    logic        mask_all;
    logic        delete_id;
    logic        pop;
    logic        set_active;
    logic        clr_active;
    logic        emit;
    stq_status_t status;
    logic        exp_valid;
    logic        last;
  } stq_cmd_t;

  // datapath to controller
  typedef struct packed {
    stq_req_t req;
    logic     active;
    logic     full;
    logic     head_due;
    logic     next_due;
    logic     out_free;
  } stq_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stq_if.sv =====
// valid/ready channel interfaces for request and result of the timer queue
// depends on nothing
`default_nettype none

interface stq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  timer_id;
  logic [31:0] expire_time;
  logic [31:0] now_time;

  modport source (output valid, req_type, timer_id, expire_time, now_time, input ready);
  modport sink   (input valid, req_type, timer_id, expire_time, now_time, output ready);
endinterface

interface stq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       expired_valid;
  logic [3:0] expired_id;
  logic       last;

  modport source (output valid, status, expired_valid, expired_id, last, input ready);
  modport sink   (input valid, status, expired_valid, expired_id, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stq_dp.sv =====
// datapath of the timer queue: sorted cell chain, active flags, result register
// depends on stq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module stq_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stq_pkg::stq_cmd_t     cmd,
  output stq_pkg::stq_stat_t    stat,
  input  logic [1:0]            in_req_type,
  input  logic [3:0]            in_timer_id,
  input  logic [31:0]           in_expire_time,
  input  logic [31:0]           in_now_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic                  out_expired_valid,
  output logic [3:0]            out_expired_id,
  output logic                  out_last
);
  import stq_pkg::*;

  localparam int NCELL = QUEUE_LIMIT;

  // request registers
  stq_req_t  req_r;
  stq_id_t   tid_r;
  stq_time_t t_r;
  stq_time_t now_r;

  // cell chain, sorted by expiry, valid cells packed from cell 0
  stq_id_t    id_r   [NCELL];
  stq_id_t    id_nxt [NCELL];
  stq_time_t  exp_r  [NCELL];
  stq_time_t  exp_nxt[NCELL];
  logic [NCELL-1:0] vld_r, vld_nxt;
  logic [NCELL-1:0] from_mask_r, from_mask_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [NUM_IDS-1:0] act_r, act_nxt;

  // result register
  logic        out_vld_r;
  stq_status_t status_r;
  logic        xv_r;
  stq_id_t     xid_r;
  logic        last_r;
  logic        out_free;

  // per-cell decisions
  logic [NCELL-1:0] match, lt_old, after, ge, take, shift, ins_mask;
  logic             sort_ok;
  logic             packed_ok;
  logic             flags_ok;

  // latch request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= stq_req_t'(in_req_type);
      tid_r <= in_timer_id;
      t_r   <= TIME_WIDTH'(in_expire_time);
      now_r <= TIME_WIDTH'(in_now_time);
    end
  end

  // local compares of every cell
  always_comb begin
    ins_mask = cmd.mask_all ? {NCELL{1'b1}} : from_mask_r;
    for (int i = 0; i < NCELL; i++) begin
      match[i]  = vld_r[i] && (id_r[i] == tid_r);
      lt_old[i] = match[i] && (t_r < exp_r[i]);
      ge[i]     = (!vld_r[i] || (exp_r[i] >= t_r)) && ins_mask[i];
    end
    for (int i = 0; i < NCELL; i++) begin
      after[i] = |(match & ({NCELL{1'b1}} >> (NCELL - 1 - i)));
    end
    take[0]  = ge[0];
    shift[0] = 1'b0;
    for (int i = 1; i < NCELL; i++) begin
      take[i]  = ge[i] && !ge[i-1];
      shift[i] = ge[i] && ge[i-1];
    end
  end

  // next cell contents: insert opens a gap, delete or pop closes one
  always_comb begin
    id_nxt        = id_r;
    exp_nxt       = exp_r;
    vld_nxt       = vld_r;
    from_mask_nxt = from_mask_r;
    count_nxt     = count_r;
    if (cmd.insert) begin
      count_nxt = count_r + CNT_W'(1);
      if (take[0]) begin
        id_nxt[0]  = tid_r;
        exp_nxt[0] = t_r;
        vld_nxt[0] = 1'b1;
      end
      for (int i = 1; i < NCELL; i++) begin
        if (take[i]) begin
          id_nxt[i]  = tid_r;
          exp_nxt[i] = t_r;
          vld_nxt[i] = 1'b1;
        end else if (shift[i]) begin
          id_nxt[i]  = id_r[i-1];
          exp_nxt[i] = exp_r[i-1];
          vld_nxt[i] = vld_r[i-1];
        end
      end
    end else if (cmd.delete_id || cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
      for (int i = 0; i < NCELL - 1; i++) begin
        if (cmd.pop || after[i]) begin
          id_nxt[i]  = id_r[i+1];
          exp_nxt[i] = exp_r[i+1];
          vld_nxt[i] = vld_r[i+1];
        end
      end
      if (cmd.pop || after[NCELL-1]) begin
        vld_nxt[NCELL-1] = 1'b0;
      end
      // an earlier expiry reinserts from the head, a later one from the gap
      if (cmd.delete_id) begin
        from_mask_nxt = (|lt_old) ? {NCELL{1'b1}} : after;
      end
    end
  end

  // active flags per id
  always_comb begin
    act_nxt = act_r;
    if (cmd.set_active) act_nxt[tid_r] = 1'b1;
    if (cmd.clr_active) act_nxt[tid_r] = 1'b0;
    if (cmd.pop)        act_nxt[id_r[0]] = 1'b0;
  end

  // cell and flag registers
  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    exp_r       <= exp_nxt;
    from_mask_r <= from_mask_nxt;
    if (!rst_n) begin
      vld_r   <= '0;
      count_r <= '0;
      act_r   <= '0;
    end else begin
      vld_r   <= vld_nxt;
      count_r <= count_nxt;
      act_r   <= act_nxt;
    end
  end

  // result register
  assign out_free = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status_r <= cmd.status;
      xv_r     <= cmd.exp_valid;
      xid_r    <= cmd.exp_valid ? id_r[0] : '0;
      last_r   <= cmd.last;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_status        = status_r;
  assign out_expired_valid = xv_r;
  assign out_expired_id    = xid_r;
  assign out_last          = last_r;

  // status to controller
  always_comb begin
    stat.req      = req_r;
    stat.active   = act_r[tid_r];
    stat.full     = count_r >= CNT_W'(NCELL);
    stat.head_due = vld_r[0] && (now_r >= exp_r[0]);
    stat.next_due = vld_r[1] && (now_r >= exp_r[1]);
    stat.out_free = out_free;
  end

  // chain order check
  always_comb begin
    sort_ok = 1'b1;
    for (int i = 0; i < NCELL - 1; i++) begin
      if (vld_r[i] && vld_r[i+1] && (exp_r[i] > exp_r[i+1])) sort_ok = 1'b0;
    end
  end

  // valid cells packed from cell 0 and matching the count
  assign packed_ok = ((vld_r & (vld_r + NCELL'(1))) == '0) &&
                     ($countones(vld_r) == int'(count_r));

  // one timer may sit unlinked while an adjust reinserts it
  assign flags_ok = ($countones(act_r) == int'(count_r)) ||
                    ($countones(act_r) == int'(count_r) + 1);

  `STQ_ASSERT(a_sorted, clk, rst_n, sort_ok)
  `STQ_ASSERT(a_packed, clk, rst_n, packed_ok)
  `STQ_ASSERT(a_emit_free, clk, rst_n, cmd.emit |-> out_free)
  `STQ_ASSERT(a_flags_count, clk, rst_n, flags_ok)
  `STQ_ASSERT_NR(a_reset, clk, !rst_n |=> (!out_vld_r && (vld_r == '0)))

endmodule

`default_nettype wire

// ===== hw/rtl/stq_ctrl.sv =====
// controller of the timer queue: sequences check, reinsert and tick pops
// depends on stq_pkg
`default_nettype none

module stq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  stq_pkg::stq_stat_t  stat,
  output stq_pkg::stq_cmd_t   cmd
);
  import stq_pkg::*;

  stq_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (stq_req_t'(in_req_type) == REQ_TICK) ? S_TICK : S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.out_free) begin
          state_nxt = (stat.req == REQ_ADJUST && stat.active) ? S_INSERT : S_IDLE;
        end
      end
      S_INSERT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_TICK: begin
        if (stat.out_free && (!stat.head_due || !stat.next_due)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.status = STAT_OK;
    cmd.last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK: begin
        if (stat.out_free) begin
          case (stat.req)
            REQ_ADD: begin
              cmd.emit = 1'b1;
              if (stat.active || stat.full) begin
                cmd.status = STAT_EXISTS;
              end else begin
                cmd.insert     = 1'b1;
                cmd.mask_all   = 1'b1;
                cmd.set_active = 1'b1;
              end
            end
            REQ_ADJUST: begin
              // unlink now, reinsert next cycle
              if (stat.active) begin
                cmd.delete_id = 1'b1;
              end else begin
                cmd.emit   = 1'b1;
                cmd.status = STAT_NOT_ACTIVE;
              end
            end
            REQ_REMOVE: begin
              cmd.emit = 1'b1;
              if (stat.active) begin
                cmd.delete_id  = 1'b1;
                cmd.clr_active = 1'b1;
              end else begin
                cmd.status = STAT_NOT_ACTIVE;
              end
            end
            default: ;
          endcase
        end
      end
      S_INSERT: begin
        if (stat.out_free) begin
          cmd.insert = 1'b1;
          cmd.emit   = 1'b1;
        end
      end
      S_TICK: begin
        // one pop per cycle while the head has expired and the output register is free
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.head_due) begin
            cmd.pop       = 1'b1;
            cmd.exp_valid = 1'b1;
            cmd.last      = !stat.next_due;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_timer_queue_unit.sv =====
// Sorted timer queue: up to 16 timers kept in ascending expiry order.
// Requests arrive on in_req (valid/ready): add, adjust, remove or tick with
// the current time. Results leave on out_rsp (valid/ready): one status for
// add, adjust and remove; for tick one result per expired timer in expiry
// order, or a single empty result, with last set on the final one.
// Flow: add and remove are latched in S_IDLE and their result is written
// from S_CHECK; adjust unlinks in S_CHECK, then reinserts and writes its
// result from S_INSERT; tick writes its results from S_TICK. A new request
// is taken only once the previous one has written its last result into
// the output register, so requests do not overlap; the controller moves
// the sorted cell chain by one insert, delete or pop per cycle while the
// output register is free.
// Reset (rst_n low, synchronous) empties the queue and clears all active
// flags and the output register. When the receiver holds out_rsp.ready low
// the finished result waits in the output register and the controller holds
// the next write, so nothing is lost or repeated.
// depends on stq_pkg, stq_if, stq_ctrl and stq_dp
`default_nettype none

module sorted_timer_queue_unit (
  input  logic       clk,
  input  logic       rst_n,
  stq_in_if.sink     in_req,
  stq_out_if.source  out_rsp
);
  import stq_pkg::*;

  stq_cmd_t  cmd;
  stq_stat_t stat;

  // sequencer
  stq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_ready    (in_req.ready),
    .in_req_type (in_req.req_type),
    .stat        (stat),
    .cmd         (cmd)
  );

  // cell chain and result register
  stq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_req_type       (in_req.req_type),
    .in_timer_id       (in_req.timer_id),
    .in_expire_time    (in_req.expire_time),
    .in_now_time       (in_req.now_time),
    .out_valid         (out_rsp.valid),
    .out_ready         (out_rsp.ready),
    .out_status        (out_rsp.status),
    .out_expired_valid (out_rsp.expired_valid),
    .out_expired_id    (out_rsp.expired_id),
    .out_last          (out_rsp.last)
  );

endmodule

`default_nettype wire
